@@ design/ctcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ctcs_pkg
// shared constants, codes and controller/datapath types of the contingency
// table chi-square unit
// ----------------------------------------------------------------------------
package ctcs_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int LINE_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int DIM_W   = 5;
  localparam int CELL_AW = ROW_W + COL_W;
  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int K_W     = $clog2(MAX_ROWS + MAX_COLS);

  localparam int CNT_W   = COUNT_BITS;
  localparam int PROD_W  = 2 * CNT_W;
  localparam int SQ_W    = 2 * PROD_W;
  localparam int NUM_W   = SQ_W + FRAC_BITS;
  localparam int DEN_W   = 3 * CNT_W;
  localparam int CHI_W   = 56;
  localparam int MINE_W  = 48;
  localparam int QUO_W   = CHI_W;
  localparam int DIVC_W  = $clog2(NUM_W + 1);
  localparam int EMPTY_W = 9;
  localparam int KIND_W  = 3;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 32;
  localparam int OUT_CNT_W = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CHI_W-1:0]  CHI_MAX  = {CHI_W{1'b1}};
  localparam logic [MINE_W-1:0] MINE_MAX = {MINE_W{1'b1}};

  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CULL  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_STAT  = 2'd3;

  localparam logic [KIND_W-1:0] RK_ACK  = 3'd0;
  localparam logic [KIND_W-1:0] RK_ROW  = 3'd1;
  localparam logic [KIND_W-1:0] RK_COL  = 3'd2;
  localparam logic [KIND_W-1:0] RK_DONE = 3'd3;
  localparam logic [KIND_W-1:0] RK_STAT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CNT  = 2'd2;

  localparam logic [2:0] MS_LAST = 3'd4;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT    = 5'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd2;
  localparam logic [OP_W-1:0] OP_PUSH      = 5'd3;
  localparam logic [OP_W-1:0] OP_CULL_ERR  = 5'd4;
  localparam logic [OP_W-1:0] OP_CULL_INIT = 5'd5;
  localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd6;
  localparam logic [OP_W-1:0] OP_SCAN_RD   = 5'd7;
  localparam logic [OP_W-1:0] OP_SCAN_NEXT = 5'd8;
  localparam logic [OP_W-1:0] OP_PICK      = 5'd9;
  localparam logic [OP_W-1:0] OP_DROP_RD   = 5'd10;
  localparam logic [OP_W-1:0] OP_DROP_SUB  = 5'd11;
  localparam logic [OP_W-1:0] OP_DROP_FIN  = 5'd12;
  localparam logic [OP_W-1:0] OP_CULL_DONE = 5'd13;
  localparam logic [OP_W-1:0] OP_STAT_INIT = 5'd14;
  localparam logic [OP_W-1:0] OP_ST_RD     = 5'd15;
  localparam logic [OP_W-1:0] OP_ST_OBS    = 5'd16;
  localparam logic [OP_W-1:0] OP_ST_ON     = 5'd17;
  localparam logic [OP_W-1:0] OP_ST_DIFF   = 5'd18;
  localparam logic [OP_W-1:0] OP_DIVM_GO   = 5'd19;
  localparam logic [OP_W-1:0] OP_MINE      = 5'd20;
  localparam logic [OP_W-1:0] OP_MSTEP     = 5'd21;
  localparam logic [OP_W-1:0] OP_DIVC_GO   = 5'd22;
  localparam logic [OP_W-1:0] OP_CHI       = 5'd23;
  localparam logic [OP_W-1:0] OP_STAT_EMIT = 5'd24;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic push_err;
    logic degen;
    logic cull_more;
    logic cell_bad;
    logic scan_last;
    logic line_last;
    logic tbl_empty;
    logic n_zero;
    logic chi_go;
    logic ms_last;
    logic div_done;
  } stat_t;

endpackage

@@ design/ctcs_ram.sv @@
// ----------------------------------------------------------------------------
// ctcs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module ctcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ctcs_div.sv @@
// ----------------------------------------------------------------------------
// ctcs_div
// bit-serial restoring divider, one quotient bit per cycle, saturating
// quotient at the mine or chi limit
// ----------------------------------------------------------------------------
module ctcs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       lim_mine_i,
  input  logic [ctcs_pkg::NUM_W-1:0] num_i,
  input  logic [ctcs_pkg::DEN_W-1:0] den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [ctcs_pkg::QUO_W-1:0] quo_o
);
  import ctcs_pkg::*;

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [DEN_W:0]    rem_s, rem_n;
  logic [DIVC_W-1:0] cnt_q;
  logic [QUO_W-1:0]  q_q;
  logic              sat_q, lim_q, busy_q, done_q, ge;

  assign rem_s = {rem_q, num_q[NUM_W-1]};
  assign ge    = rem_s >= {1'b0, den_q};
  assign rem_n = ge ? rem_s - {1'b0, den_q} : rem_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      q_q    <= '0;
      sat_q  <= 1'b0;
      lim_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIVC_W'(NUM_W);
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      q_q    <= '0;
      sat_q  <= 1'b0;
      lim_q  <= lim_mine_i;
    end else if (busy_q) begin
      rem_q <= rem_n[DEN_W-1:0];
      num_q <= num_q << 1;
      q_q   <= {q_q[QUO_W-2:0], ge};
      sat_q <= sat_q | (lim_q ? q_q[MINE_W-1] : q_q[QUO_W-1]);
      cnt_q <= cnt_q - DIVC_W'(1);
      if (cnt_q == DIVC_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = sat_q ? (lim_q ? QUO_W'(MINE_MAX) : CHI_MAX) : q_q;

endmodule

@@ design/ctcs_dp.sv @@
// ----------------------------------------------------------------------------
// ctcs_dp
// datapath: table storage, marginals, row/column maps, shared multiplier,
// divider and result register
// ----------------------------------------------------------------------------
module ctcs_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctcs_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [ctcs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [ctcs_pkg::ROW_W-1:0]     row_index_i,
  input  logic [ctcs_pkg::COL_W-1:0]     col_index_i,
  input  ctcs_pkg::cmd_t                 cmd_i,
  output ctcs_pkg::stat_t                stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ctcs_pkg::KIND_W-1:0]    result_kind_o,
  output logic [3:0]                     victim_index_o,
  output logic [ctcs_pkg::OUT_CNT_W-1:0] count_value_o,
  output logic [ctcs_pkg::CHI_W-1:0]     chi_square_q16_o,
  output logic [ctcs_pkg::MINE_W-1:0]    min_expected_q16_o,
  output logic [ctcs_pkg::EMPTY_W-1:0]   empty_cells_o,
  output logic [ctcs_pkg::DIM_W-1:0]     rows_now_o,
  output logic [ctcs_pkg::DIM_W-1:0]     cols_now_o,
  output logic                           error_o,
  output logic                           last_o
);
  import ctcs_pkg::*;

  logic [DIM_W-1:0]  num_rows_q, num_cols_q;
  logic [CNT_W-1:0]  min_cnt_q;
  logic [DIM_W-1:0]  act_rows_q, act_cols_q, rows_nx, cols_nx;
  logic [CNT_W-1:0]  total_q;
  logic [CNT_W-1:0]  row_tot_q [MAX_ROWS];
  logic [CNT_W-1:0]  col_tot_q [MAX_COLS];
  logic [ROW_W-1:0]  rmap_q [MAX_ROWS];
  logic [COL_W-1:0]  cmap_q [MAX_COLS];
  logic [ROW_W-1:0]  rmap_sh [MAX_ROWS];
  logic [COL_W-1:0]  cmap_sh [MAX_COLS];
  logic [CELLS-1:0]  valid_q;
  logic [ROW_W-1:0]  ri_q, r_q, ridx, prow;
  logic [COL_W-1:0]  ci_q, c_q, cidx, pcol;
  logic [LINE_W-1:0] j_q, v_q;
  logic              dir_q;
  logic [K_W-1:0]    k_q;
  logic [CELL_AW-1:0] addr, addr_q;
  logic              vrd_q, re;
  logic [CNT_W-1:0]  rdata, val, rt_sel, ct_sel;
  logic [CNT_W-1:0]  rt_q, ct_q, o_q;
  logic [PROD_W-1:0] rc_q, on_q, d_q, nr_q, mul_p;
  logic [CNT_W-1:0]  mul_a, mul_b;
  logic [SQ_W-1:0]   sq_q;
  logic [DEN_W-1:0]  den_q;
  logic [2:0]        ms_q;
  logic [CHI_W-1:0]  chi_q;
  logic [CHI_W:0]    chi_sum;
  logic [MINE_W-1:0] mine_q, e_new;
  logic              have_q;
  logic [EMPTY_W-1:0] empty_q;
  logic              push_err, out_free, out_load, by_row0, by_row;
  logic              div_start, div_busy, div_done, div_mine;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [QUO_W-1:0]  div_quo;

  logic              out_valid_q, out_err_q, out_last_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [3:0]        out_victim_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;
  logic [CHI_W-1:0]  out_chi_q;
  logic [MINE_W-1:0] out_mine_q;
  logic [EMPTY_W-1:0] out_empty_q;
  logic [DIM_W-1:0]  out_rows_q, out_cols_q;

  // map index select
  always_comb begin
    ridx = r_q;
    cidx = c_q;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        ridx = row_index_i;
        cidx = col_index_i;
      end
      OP_PUSH: begin
        ridx = ri_q;
        cidx = ci_q;
      end
      OP_DROP_RD, OP_DROP_SUB: begin
        ridx = dir_q ? v_q[ROW_W-1:0] : j_q[ROW_W-1:0];
        cidx = dir_q ? j_q[COL_W-1:0] : v_q[COL_W-1:0];
      end
      OP_DROP_FIN: begin
        ridx = v_q[ROW_W-1:0];
        cidx = v_q[COL_W-1:0];
      end
      default: begin
        ridx = r_q;
        cidx = c_q;
      end
    endcase
  end

  assign prow   = rmap_q[ridx];
  assign pcol   = cmap_q[cidx];
  assign rt_sel = row_tot_q[prow];
  assign ct_sel = col_tot_q[pcol];
  assign addr   = {prow, pcol};
  assign re     = (cmd_i.op == OP_ACCEPT) || (cmd_i.op == OP_SCAN_RD) ||
                  (cmd_i.op == OP_ST_RD) || (cmd_i.op == OP_DROP_RD);
  assign val    = vrd_q ? rdata : '0;

  ctcs_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_cells (
    .clk_i   (clk_i),
    .we_i    ((cmd_i.op == OP_PUSH) && !push_err),
    .waddr_i (addr_q),
    .wdata_i (val + CNT_W'(1)),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // rotate the removed line to the end of the map
  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (i < MAX_ROWS - 1) begin
        rmap_sh[i] = (ROW_W'(i) >= v_q[ROW_W-1:0]) ? rmap_q[(i + 1) % MAX_ROWS] : rmap_q[i];
      end else begin
        rmap_sh[i] = prow;
      end
    end
    for (int i = 0; i < MAX_COLS; i++) begin
      if (i < MAX_COLS - 1) begin
        cmap_sh[i] = (COL_W'(i) >= v_q[COL_W-1:0]) ? cmap_q[(i + 1) % MAX_COLS] : cmap_q[i];
      end else begin
        cmap_sh[i] = pcol;
      end
    end
  end

  assign push_err = (DIM_W'(ri_q) >= act_rows_q) || (DIM_W'(ci_q) >= act_cols_q) ||
                    (total_q == CNT_MAX);
  assign by_row0  = rt_sel < ct_sel;
  assign by_row   = (by_row0 ? (act_rows_q <= DIM_W'(2)) : (act_cols_q <= DIM_W'(2))) ?
                    !by_row0 : by_row0;

  always_comb begin
    rows_nx = act_rows_q;
    cols_nx = act_cols_q;
    if (cmd_i.op == OP_CLEAR) begin
      rows_nx = (num_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : num_rows_q;
      cols_nx = (num_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : num_cols_q;
    end else if (cmd_i.op == OP_DROP_FIN) begin
      if (dir_q) begin
        rows_nx = act_rows_q - DIM_W'(1);
      end else begin
        cols_nx = act_cols_q - DIM_W'(1);
      end
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = rt_q;
    mul_b = ct_q;
    unique case (cmd_i.op)
      OP_ST_ON: begin
        mul_a = o_q;
        mul_b = total_q;
      end
      OP_ST_DIFF: begin
        mul_a = total_q;
        mul_b = rt_q;
      end
      OP_MSTEP: begin
        unique case (ms_q)
          3'd0: begin
            mul_a = d_q[CNT_W-1:0];
            mul_b = d_q[CNT_W-1:0];
          end
          3'd1: begin
            mul_a = d_q[CNT_W-1:0];
            mul_b = d_q[PROD_W-1:CNT_W];
          end
          3'd2: begin
            mul_a = d_q[PROD_W-1:CNT_W];
            mul_b = d_q[PROD_W-1:CNT_W];
          end
          3'd3: begin
            mul_a = nr_q[CNT_W-1:0];
            mul_b = ct_q;
          end
          default: begin
            mul_a = nr_q[PROD_W-1:CNT_W];
            mul_b = ct_q;
          end
        endcase
      end
      default: begin
        mul_a = rt_q;
        mul_b = ct_q;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign div_start = (cmd_i.op == OP_DIVM_GO) || (cmd_i.op == OP_DIVC_GO);
  assign div_mine  = cmd_i.op == OP_DIVM_GO;
  assign div_num   = div_mine ? NUM_W'({rc_q, {FRAC_BITS{1'b0}}}) : {sq_q, {FRAC_BITS{1'b0}}};
  assign div_den   = div_mine ? DEN_W'(total_q) : den_q;

  ctcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .lim_mine_i (div_mine),
    .num_i      (div_num),
    .den_i      (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign e_new   = div_quo[MINE_W-1:0];
  assign chi_sum = {1'b0, chi_q} + {1'b0, div_quo};

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_PUSH) ||
                    (cmd_i.op == OP_CULL_ERR) || (cmd_i.op == OP_DROP_FIN) ||
                    (cmd_i.op == OP_CULL_DONE) || (cmd_i.op == OP_STAT_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_W'(2);
      num_cols_q <= DIM_W'(2);
      min_cnt_q  <= CNT_W'(5);
      act_rows_q <= DIM_W'(2);
      act_cols_q <= DIM_W'(2);
      total_q    <= '0;
      valid_q    <= '0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        row_tot_q[i] <= '0;
        rmap_q[i]    <= ROW_W'(i);
      end
      for (int i = 0; i < MAX_COLS; i++) begin
        col_tot_q[i] <= '0;
        cmap_q[i]    <= COL_W'(i);
      end
      ri_q <= '0; ci_q <= '0; r_q <= '0; c_q <= '0; j_q <= '0; v_q <= '0;
      dir_q <= 1'b0; k_q <= '0; addr_q <= '0; vrd_q <= 1'b0;
      rt_q <= '0; ct_q <= '0; o_q <= '0; rc_q <= '0; on_q <= '0; d_q <= '0;
      nr_q <= '0; sq_q <= '0; den_q <= '0; ms_q <= '0;
      chi_q <= '0; mine_q <= '0; have_q <= 1'b0; empty_q <= '0;
      out_valid_q <= 1'b0;
      out_kind_q <= RK_ACK; out_victim_q <= '0; out_cnt_q <= '0; out_chi_q <= '0;
      out_mine_q <= '0; out_empty_q <= '0; out_rows_q <= '0; out_cols_q <= '0;
      out_err_q <= 1'b0; out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_NUM_ROWS: num_rows_q <= cfg_data_i[DIM_W-1:0];
          CFG_NUM_COLS: num_cols_q <= cfg_data_i[DIM_W-1:0];
          CFG_MIN_CNT:  min_cnt_q  <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      if (re) begin
        addr_q <= addr;
        vrd_q  <= valid_q[addr];
      end

      act_rows_q <= rows_nx;
      act_cols_q <= cols_nx;

      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_kind_q   <= RK_ACK;
        out_victim_q <= '0;
        out_cnt_q    <= '0;
        out_chi_q    <= '0;
        out_mine_q   <= '0;
        out_empty_q  <= '0;
        out_rows_q   <= rows_nx;
        out_cols_q   <= cols_nx;
        out_err_q    <= 1'b0;
        out_last_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (cmd_i.op)
        OP_ACCEPT: begin
          ri_q <= row_index_i;
          ci_q <= col_index_i;
        end
        OP_CLEAR: begin
          valid_q <= '0;
          total_q <= '0;
          for (int i = 0; i < MAX_ROWS; i++) begin
            row_tot_q[i] <= '0;
            rmap_q[i]    <= ROW_W'(i);
          end
          for (int i = 0; i < MAX_COLS; i++) begin
            col_tot_q[i] <= '0;
            cmap_q[i]    <= COL_W'(i);
          end
        end
        OP_PUSH: begin
          if (push_err) begin
            out_cnt_q <= OUT_CNT_W'(total_q);
            out_err_q <= 1'b1;
          end else begin
            valid_q[addr_q]  <= 1'b1;
            row_tot_q[prow]  <= rt_sel + CNT_W'(1);
            col_tot_q[pcol]  <= ct_sel + CNT_W'(1);
            total_q          <= total_q + CNT_W'(1);
            out_cnt_q        <= OUT_CNT_W'(total_q + CNT_W'(1));
          end
        end
        OP_CULL_ERR: begin
          out_kind_q <= RK_DONE;
          out_err_q  <= 1'b1;
        end
        OP_CULL_INIT: k_q <= '0;
        OP_SCAN_INIT: begin
          r_q <= '0;
          c_q <= '0;
        end
        OP_SCAN_NEXT: begin
          if (DIM_W'(c_q) == act_cols_q - DIM_W'(1)) begin
            c_q <= '0;
            r_q <= r_q + ROW_W'(1);
          end else begin
            c_q <= c_q + COL_W'(1);
          end
        end
        OP_PICK: begin
          dir_q <= by_row;
          v_q   <= by_row ? LINE_W'(r_q) : LINE_W'(c_q);
          j_q   <= '0;
        end
        OP_DROP_SUB: begin
          if (dir_q) begin
            col_tot_q[pcol] <= ct_sel - val;
          end else begin
            row_tot_q[prow] <= rt_sel - val;
          end
          j_q <= j_q + LINE_W'(1);
        end
        OP_DROP_FIN: begin
          if (dir_q) begin
            total_q <= total_q - rt_sel;
            for (int i = 0; i < MAX_ROWS; i++) begin
              rmap_q[i] <= rmap_sh[i];
            end
            out_kind_q <= RK_ROW;
          end else begin
            total_q <= total_q - ct_sel;
            for (int i = 0; i < MAX_COLS; i++) begin
              cmap_q[i] <= cmap_sh[i];
            end
            out_kind_q <= RK_COL;
          end
          k_q          <= k_q + K_W'(1);
          out_victim_q <= v_q[3:0];
          out_last_q   <= 1'b0;
        end
        OP_CULL_DONE: begin
          out_kind_q <= RK_DONE;
          out_cnt_q  <= OUT_CNT_W'(k_q);
        end
        OP_STAT_INIT: begin
          r_q     <= '0;
          c_q     <= '0;
          chi_q   <= '0;
          mine_q  <= '0;
          have_q  <= 1'b0;
          empty_q <= '0;
        end
        OP_ST_RD: begin
          rt_q <= rt_sel;
          ct_q <= ct_sel;
        end
        OP_ST_OBS: begin
          o_q  <= val;
          rc_q <= mul_p;
          if (val == '0) begin
            empty_q <= empty_q + EMPTY_W'(1);
          end
        end
        OP_ST_ON: on_q <= mul_p;
        OP_ST_DIFF: begin
          d_q  <= (on_q > rc_q) ? on_q - rc_q : rc_q - on_q;
          nr_q <= mul_p;
          ms_q <= '0;
        end
        OP_MINE: begin
          if (!have_q || (e_new < mine_q)) begin
            mine_q <= e_new;
            have_q <= 1'b1;
          end
        end
        OP_MSTEP: begin
          ms_q <= ms_q + 3'd1;
          unique case (ms_q)
            3'd0: sq_q  <= SQ_W'(mul_p);
            3'd1: sq_q  <= sq_q + (SQ_W'(mul_p) << (CNT_W + 1));
            3'd2: sq_q  <= sq_q + (SQ_W'(mul_p) << PROD_W);
            3'd3: den_q <= DEN_W'(mul_p);
            default: den_q <= den_q + (DEN_W'(mul_p) << CNT_W);
          endcase
        end
        OP_CHI: chi_q <= chi_sum[CHI_W] ? CHI_MAX : chi_sum[CHI_W-1:0];
        OP_STAT_EMIT: begin
          out_kind_q  <= RK_STAT;
          out_cnt_q   <= OUT_CNT_W'(total_q);
          out_chi_q   <= chi_q;
          out_mine_q  <= mine_q;
          out_empty_q <= empty_q;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.out_free  = out_free;
  assign stat_o.push_err  = push_err;
  assign stat_o.degen     = (act_rows_q < DIM_W'(2)) || (act_cols_q < DIM_W'(2));
  assign stat_o.cull_more = (act_rows_q > DIM_W'(2)) || (act_cols_q > DIM_W'(2));
  assign stat_o.cell_bad  = val < min_cnt_q;
  assign stat_o.scan_last = (DIM_W'(r_q) == act_rows_q - DIM_W'(1)) &&
                            (DIM_W'(c_q) == act_cols_q - DIM_W'(1));
  assign stat_o.line_last = DIM_W'(j_q) == ((dir_q ? act_cols_q : act_rows_q) - DIM_W'(1));
  assign stat_o.tbl_empty = (act_rows_q == '0) || (act_cols_q == '0);
  assign stat_o.n_zero    = total_q == '0;
  assign stat_o.chi_go    = (o_q != '0) && (rt_q != '0) && (ct_q != '0);
  assign stat_o.ms_last   = ms_q == MS_LAST;
  assign stat_o.div_done  = div_done;

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign victim_index_o     = out_victim_q;
  assign count_value_o      = out_cnt_q;
  assign chi_square_q16_o   = out_chi_q;
  assign min_expected_q16_o = out_mine_q;
  assign empty_cells_o      = out_empty_q;
  assign rows_now_o         = out_rows_q;
  assign cols_now_o         = out_cols_q;
  assign error_o            = out_err_q;
  assign last_o             = out_last_q;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result overwritten before transfer");
  a_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_rows_q <= DIM_W'(MAX_ROWS)) && (act_cols_q <= DIM_W'(MAX_COLS)))
    else $error("table dimension out of range");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_drop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DROP_FIN) |=> (act_rows_q + act_cols_q ==
    $past(act_rows_q) + $past(act_cols_q) - DIM_W'(1))) else $error("drop did not shrink table");
`endif

endmodule

@@ design/ctcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctcs_ctrl
// controller: sequences clear, push, cull and statistic items over the
// datapath
// ----------------------------------------------------------------------------
module ctcs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ctcs_pkg::FUNC_W-1:0] func_i,
  input  ctcs_pkg::stat_t             stat_i,
  output ctcs_pkg::cmd_t              cmd_o
);
  import ctcs_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_PUSH  = 5'd2;
  localparam logic [4:0] S_CULL  = 5'd3;
  localparam logic [4:0] S_CTEST = 5'd4;
  localparam logic [4:0] S_SRD   = 5'd5;
  localparam logic [4:0] S_SCHK  = 5'd6;
  localparam logic [4:0] S_DRD   = 5'd7;
  localparam logic [4:0] S_DSUB  = 5'd8;
  localparam logic [4:0] S_DFIN  = 5'd9;
  localparam logic [4:0] S_CDONE = 5'd10;
  localparam logic [4:0] S_STAT  = 5'd11;
  localparam logic [4:0] S_TRD   = 5'd12;
  localparam logic [4:0] S_TOBS  = 5'd13;
  localparam logic [4:0] S_TON   = 5'd14;
  localparam logic [4:0] S_TDIFF = 5'd15;
  localparam logic [4:0] S_TDIVM = 5'd16;
  localparam logic [4:0] S_TDMW  = 5'd17;
  localparam logic [4:0] S_TMUL  = 5'd18;
  localparam logic [4:0] S_TDIVC = 5'd19;
  localparam logic [4:0] S_TDCW  = 5'd20;
  localparam logic [4:0] S_TNEXT = 5'd21;
  localparam logic [4:0] S_TEMIT = 5'd22;

  logic [4:0] state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          unique case (func_i)
            FN_CLEAR: state_d = S_CLR;
            FN_PUSH:  state_d = S_PUSH;
            FN_CULL:  state_d = S_CULL;
            default:  state_d = S_STAT;
          endcase
        end
      end
      S_CLR: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_CLEAR;
          state_d  = S_IDLE;
        end
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      S_CULL: begin
        if (stat_i.degen) begin
          if (stat_i.out_free) begin
            cmd_o.op = OP_CULL_ERR;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_CULL_INIT;
          state_d  = S_CTEST;
        end
      end
      S_CTEST: begin
        if (stat_i.cull_more) begin
          cmd_o.op = OP_SCAN_INIT;
          state_d  = S_SRD;
        end else begin
          state_d = S_CDONE;
        end
      end
      S_SRD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = S_SCHK;
      end
      S_SCHK: begin
        priority if (stat_i.cell_bad) begin
          cmd_o.op = OP_PICK;
          state_d  = S_DRD;
        end else if (stat_i.scan_last) begin
          state_d = S_CDONE;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_SRD;
        end
      end
      S_DRD: begin
        cmd_o.op = OP_DROP_RD;
        state_d  = S_DSUB;
      end
      S_DSUB: begin
        cmd_o.op = OP_DROP_SUB;
        state_d  = stat_i.line_last ? S_DFIN : S_DRD;
      end
      S_DFIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_DROP_FIN;
          state_d  = S_CTEST;
        end
      end
      S_CDONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_CULL_DONE;
          state_d  = S_IDLE;
        end
      end
      S_STAT: begin
        cmd_o.op = OP_STAT_INIT;
        state_d  = stat_i.tbl_empty ? S_TEMIT : S_TRD;
      end
      S_TRD: begin
        cmd_o.op = OP_ST_RD;
        state_d  = S_TOBS;
      end
      S_TOBS: begin
        cmd_o.op = OP_ST_OBS;
        state_d  = S_TON;
      end
      S_TON: begin
        cmd_o.op = OP_ST_ON;
        state_d  = S_TDIFF;
      end
      S_TDIFF: begin
        cmd_o.op = OP_ST_DIFF;
        state_d  = stat_i.n_zero ? S_TNEXT : S_TDIVM;
      end
      S_TDIVM: begin
        cmd_o.op = OP_DIVM_GO;
        state_d  = S_TDMW;
      end
      S_TDMW: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_MINE;
          state_d  = stat_i.chi_go ? S_TMUL : S_TNEXT;
        end
      end
      S_TMUL: begin
        cmd_o.op = OP_MSTEP;
        if (stat_i.ms_last) begin
          state_d = S_TDIVC;
        end
      end
      S_TDIVC: begin
        cmd_o.op = OP_DIVC_GO;
        state_d  = S_TDCW;
      end
      S_TDCW: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_CHI;
          state_d  = S_TNEXT;
        end
      end
      S_TNEXT: begin
        if (stat_i.scan_last) begin
          state_d = S_TEMIT;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_TRD;
        end
      end
      S_TEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_STAT_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/contingency_table_chi_square_unit.sv @@
// ----------------------------------------------------------------------------
// contingency_table_chi_square_unit
// two-way contingency table with push, clear, cull and chi-square statistic
//
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    func, row_index, col_index
// out      out  out_valid_o / out_ready_i  result_kind .. last
// cfg      in   cfg_we_i                   cfg_addr_i, cfg_data_i
//
// push is a ram read then write
// cull reads and checks each scanned cell and reads and subtracts each cell
// of a removed line; with a nonzero total, statistic runs a bit-serial
// mine division per cell and a chi division per occupied cell
// reset is asynchronous, table comes up empty at 2x2 with no clearing pass
// a waiting result holds only the emitting step; the next item is taken
// once the result register is loaded
// ----------------------------------------------------------------------------
module contingency_table_chi_square_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctcs_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [ctcs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ctcs_pkg::FUNC_W-1:0]    func_i,
  input  logic [ctcs_pkg::ROW_W-1:0]     row_index_i,
  input  logic [ctcs_pkg::COL_W-1:0]     col_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ctcs_pkg::KIND_W-1:0]    result_kind_o,
  output logic [3:0]                     victim_index_o,
  output logic [ctcs_pkg::OUT_CNT_W-1:0] count_value_o,
  output logic [ctcs_pkg::CHI_W-1:0]     chi_square_q16_o,
  output logic [ctcs_pkg::MINE_W-1:0]    min_expected_q16_o,
  output logic [ctcs_pkg::EMPTY_W-1:0]   empty_cells_o,
  output logic [ctcs_pkg::DIM_W-1:0]     rows_now_o,
  output logic [ctcs_pkg::DIM_W-1:0]     cols_now_o,
  output logic                           error_o,
  output logic                           last_o
);
  import ctcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ctcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ctcs_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_data_i         (cfg_data_i),
    .row_index_i        (row_index_i),
    .col_index_i        (col_index_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .victim_index_o     (victim_index_o),
    .count_value_o      (count_value_o),
    .chi_square_q16_o   (chi_square_q16_o),
    .min_expected_q16_o (min_expected_q16_o),
    .empty_cells_o      (empty_cells_o),
    .rows_now_o         (rows_now_o),
    .cols_now_o         (cols_now_o),
    .error_o            (error_o),
    .last_o             (last_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the contingency table chi-square unit against a predictor of the
// table, its cull passes and its statistic, under random idling on both sides
// ----------------------------------------------------------------------------
module tb;
  import ctcs_pkg::*;

  typedef struct {
    bit [2:0]  kind;
    bit [3:0]  victim;
    bit [31:0] count;
    bit [55:0] chi;
    bit [47:0] mine;
    bit [8:0]  empty;
    bit [4:0]  rows;
    bit [4:0]  cols;
    bit        err;
    bit        last;
  } table_result_t;

  class chi_scoreboard;
    bit [31:0] cell_cnt[16][16];
    bit [31:0] row_sum[16];
    bit [31:0] col_sum[16];
    bit [31:0] total;
    bit [4:0]  rows_act, cols_act;
    bit [4:0]  rows_reg, cols_reg;
    bit [31:0] min_reg;
    table_result_t pending[$];
    int fails, results, removals, items;

    function new();
      rows_act = 2; cols_act = 2; rows_reg = 2; cols_reg = 2; min_reg = 5;
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] val);
      case (idx)
        CFG_NUM_ROWS: rows_reg = val[4:0];
        CFG_NUM_COLS: cols_reg = val[4:0];
        CFG_MIN_CNT:  min_reg = val;
        default: ;
      endcase
    endfunction

    function void add(bit [2:0] kind, bit [3:0] victim, bit [31:0] count, bit [55:0] chi,
                      bit [47:0] mine, bit [8:0] empty, bit err, bit last);
      table_result_t e;
      e.kind = kind; e.victim = victim; e.count = count; e.chi = chi; e.mine = mine;
      e.empty = empty; e.rows = rows_act; e.cols = cols_act; e.err = err; e.last = last;
      pending.push_back(e);
    endfunction

    function bit find_low(output int fr, output int fc);
      for (int r = 0; r < rows_act; r++)
        for (int c = 0; c < cols_act; c++)
          if (cell_cnt[r][c] < min_reg) begin
            fr = r; fc = c;
            return 1;
          end
      return 0;
    endfunction

    function void drop_row(int v);
      for (int c = 0; c < cols_act; c++) col_sum[c] -= cell_cnt[v][c];
      total -= row_sum[v];
      for (int r = v; r + 1 < rows_act; r++) begin
        for (int c = 0; c < cols_act; c++) cell_cnt[r][c] = cell_cnt[r+1][c];
        row_sum[r] = row_sum[r+1];
      end
      rows_act--;
    endfunction

    function void drop_col(int v);
      for (int r = 0; r < rows_act; r++) row_sum[r] -= cell_cnt[r][v];
      total -= col_sum[v];
      for (int c = v; c + 1 < cols_act; c++) begin
        for (int r = 0; r < rows_act; r++) cell_cnt[r][c] = cell_cnt[r][c+1];
        col_sum[c] = col_sum[c+1];
      end
      cols_act--;
    endfunction

    function void note_item(bit [1:0] fn, bit [3:0] ri, bit [3:0] ci);
      int k, fr, fc;
      bit by_row;
      bit [191:0] num, den, q;
      bit [63:0] on, rc, d, chi;
      bit [47:0] mine;
      bit have_min;
      bit [8:0] empty;
      items++;
      case (fn)
        FN_CLEAR: begin
          foreach (cell_cnt[r, c]) cell_cnt[r][c] = 0;
          foreach (row_sum[r]) row_sum[r] = 0;
          foreach (col_sum[c]) col_sum[c] = 0;
          total = 0;
          rows_act = (rows_reg > 16) ? 5'd16 : rows_reg;
          cols_act = (cols_reg > 16) ? 5'd16 : cols_reg;
          add(RK_ACK, 0, 0, 0, 0, 0, 0, 1);
        end
        FN_PUSH: begin
          if (ri >= rows_act || ci >= cols_act || total == CNT_MAX) begin
            add(RK_ACK, 0, total, 0, 0, 0, 1, 1);
          end else begin
            cell_cnt[ri][ci]++; row_sum[ri]++; col_sum[ci]++; total++;
            add(RK_ACK, 0, total, 0, 0, 0, 0, 1);
          end
        end
        FN_CULL: begin
          if (rows_act < 2 || cols_act < 2) begin
            add(RK_DONE, 0, 0, 0, 0, 0, 1, 1);
          end else begin
            k = 0;
            while ((rows_act > 2 || cols_act > 2) && find_low(fr, fc)) begin
              by_row = row_sum[fr] < col_sum[fc];
              if (by_row ? rows_act <= 2 : cols_act <= 2) by_row = !by_row;
              if (by_row) begin
                drop_row(fr);
                add(RK_ROW, fr, 0, 0, 0, 0, 0, 0);
              end else begin
                drop_col(fc);
                add(RK_COL, fc, 0, 0, 0, 0, 0, 0);
              end
              k++;
            end
            removals += k;
            add(RK_DONE, 0, k, 0, 0, 0, 0, 1);
          end
        end
        default: begin
          chi = 0; mine = 0; have_min = 0; empty = 0;
          for (int r = 0; r < rows_act; r++)
            for (int c = 0; c < cols_act; c++) begin
              if (total > 0) begin
                num = (192'(row_sum[r]) * 192'(col_sum[c])) << FRAC_BITS;
                q = num / 192'(total);
                if (q > 192'(MINE_MAX)) q = 192'(MINE_MAX);
                if (!have_min || q[47:0] < mine) begin
                  mine = q[47:0]; have_min = 1;
                end
              end
              if (cell_cnt[r][c] == 0) begin
                empty++;
              end else if (total > 0 && row_sum[r] > 0 && col_sum[c] > 0) begin
                on = 64'(cell_cnt[r][c]) * 64'(total);
                rc = 64'(row_sum[r]) * 64'(col_sum[c]);
                d = (on > rc) ? on - rc : rc - on;
                num = (192'(d) * 192'(d)) << FRAC_BITS;
                den = 192'(total) * 192'(row_sum[r]) * 192'(col_sum[c]);
                q = num / den;
                if (q > 192'(CHI_MAX)) q = 192'(CHI_MAX);
                chi += q[63:0];
                if (chi > 64'(CHI_MAX)) chi = 64'(CHI_MAX);
              end
            end
          add(RK_STAT, 0, total, chi[55:0], mine, empty, 0, 1);
        end
      endcase
    endfunction

    function void cmp(string name, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
        fails++;
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check(table_result_t a);
      table_result_t e;
      results++;
      if (pending.size() == 0) begin
        fails++;
        $display("%0t unexpected result kind %0d, expected none", $time, a.kind);
        return;
      end
      e = pending.pop_front();
      cmp("result_kind", e.kind, a.kind);
      cmp("victim_index", e.victim, a.victim);
      cmp("count_value", e.count, a.count);
      cmp("chi_square_q16", e.chi, a.chi);
      cmp("min_expected_q16", e.mine, a.mine);
      cmp("empty_cells", e.empty, a.empty);
      cmp("rows_now", e.rows, a.rows);
      cmp("cols_now", e.cols, a.cols);
      cmp("error", e.err, a.err);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [ROW_W-1:0] row_index_i = '0;
  logic [COL_W-1:0] col_index_i = '0;
  logic out_valid_o, out_ready_i = 0;
  logic [KIND_W-1:0] result_kind_o;
  logic [3:0] victim_index_o;
  logic [OUT_CNT_W-1:0] count_value_o;
  logic [CHI_W-1:0] chi_square_q16_o;
  logic [MINE_W-1:0] min_expected_q16_o;
  logic [EMPTY_W-1:0] empty_cells_o;
  logic [DIM_W-1:0] rows_now_o, cols_now_o;
  logic error_o, last_o;

  chi_scoreboard sb = new();
  bit idle_en = 1;
  bit hold_req = 0;
  int quiet_cycles = 0;

  contingency_table_chi_square_unit u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    table_result_t a;
    if (out_valid_o && out_ready_i) begin
      a.kind = result_kind_o; a.victim = victim_index_o; a.count = count_value_o;
      a.chi = chi_square_q16_o; a.mine = min_expected_q16_o; a.empty = empty_cells_o;
      a.rows = rows_now_o; a.cols = cols_now_o; a.err = error_o; a.last = last_o;
      sb.check(a);
    end
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 300000) begin
      $display("%0t watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver side
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 0;
        repeat (600) @(posedge clk_i);
        out_ready_i <= 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send(bit [1:0] fn, bit [3:0] ri, bit [3:0] ci);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    func_i <= fn;
    row_index_i <= ri;
    col_index_i <= ci;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(fn, ri, ci);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [31:0] val);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  initial begin
    int nr, nc, x;
    bit [31:0] mc;
    bit [3:0] ri, ci;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset table, empty statistic, range errors
    send(FN_STAT, 0, 0);
    send(FN_PUSH, 0, 0);
    send(FN_PUSH, 2, 0);
    send(FN_PUSH, 1, 15);
    send(FN_CULL, 0, 0);
    send(FN_STAT, 0, 0);
    drain();
    write_reg(CFG_NUM_ROWS, 0);
    write_reg(CFG_NUM_COLS, 3);
    send(FN_CLEAR, 0, 0);
    send(FN_PUSH, 0, 0);
    send(FN_CULL, 0, 0);
    send(FN_STAT, 0, 0);
    drain();
    // oversized table, full cull down to 2x2
    write_reg(CFG_NUM_ROWS, 31);
    write_reg(CFG_NUM_COLS, 16);
    write_reg(CFG_MIN_CNT, 0);
    send(FN_CLEAR, 0, 0);
    send(FN_PUSH, 15, 15);
    send(FN_PUSH, 0, 15);
    send(FN_PUSH, 15, 0);
    send(FN_CULL, 0, 0);
    send(FN_STAT, 0, 0);
    drain();
    write_reg(CFG_MIN_CNT, 32'hFFFF_FFFF);
    send(FN_CULL, 0, 0);
    send(FN_STAT, 0, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 13; ph++) begin
      idle_en = (ph < 10) && (ph != 6);
      nr = (ph == 4) ? 16 : $urandom_range(0, 6);
      nc = (ph == 4) ? 16 : $urandom_range(0, 6);
      x = $urandom_range(0, 9);
      mc = (x == 0) ? 32'd0 : (x == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 4);
      write_reg(CFG_NUM_ROWS, nr);
      write_reg(CFG_NUM_COLS, nc);
      write_reg(CFG_MIN_CNT, mc);
      send(FN_CLEAR, 0, 0);
      if (ph == 2) hold_req = 1;
      for (int i = 0; i < 31; i++) begin
        x = $urandom_range(0, 99);
        if (x < 2) send(FN_CLEAR, 0, 0);
        else if (x < 7) send(FN_CULL, 0, 0);
        else if (x < 11 && sb.rows_act * sb.cols_act <= 36) send(FN_STAT, 0, 0);
        else if (x < 20) send(FN_PUSH, $urandom_range(0, 15), $urandom_range(0, 15));
        else begin
          ri = $urandom_range(0, (sb.rows_act > 15) ? 15 : sb.rows_act);
          ci = $urandom_range(0, (sb.cols_act > 15) ? 15 : sb.cols_act);
          send(FN_PUSH, ri, ci);
        end
      end
      if (sb.rows_act * sb.cols_act <= 36) send(FN_STAT, 0, 0);
      send(FN_CULL, 0, 0);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d culled lines", sb.items, sb.results,
             sb.removals);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.fails, sb.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/ctcs_pkg.sv
design/ctcs_ram.sv
design/ctcs_div.sv
design/ctcs_dp.sv
design/ctcs_ctrl.sv
design/contingency_table_chi_square_unit.sv
test/tb.sv
